### rtl/assert_macros.svh
// Assertion macros used by the RTL (fm_discriminator_deemphasis_unit).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, off while reset is held.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Condition that must never be seen at a clock edge.
`define ASSERT_NEVER(lbl, expr, msg) \
  `ASSERT_CLK(lbl, !(expr), msg)

`endif

### rtl/fdd_pkg.sv
// Constants, register codes and CORDIC angle table for the FM discriminator.
package fdd_pkg;

  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POLE = 8'd1;

  localparam logic [CFG_DATA_W-1:0] GAIN_RESET = 16'd2731;
  localparam logic [CFG_DATA_W-1:0] POLE_RESET = 16'd62337;

  // phase: 2^23 units per pi
  localparam int unsigned PHASE_W     = 25;
  localparam int unsigned ANGLE_STEPS = 24;
  localparam logic signed [PHASE_W-1:0] ANGLE_PI = 25'sd8388608;

  localparam int unsigned DEMOD_W = 29;
  localparam int unsigned ACC_W   = 32;
  localparam int unsigned AUDIO_W = 18;

  // atan(2^-k), rounded, in phase units
  function automatic logic signed [PHASE_W-1:0] angle_step(input logic [4:0] k);
    logic signed [PHASE_W-1:0] a;
    unique case (k)
      5'd0:    a = 25'sd2097152;
      5'd1:    a = 25'sd1238021;
      5'd2:    a = 25'sd654136;
      5'd3:    a = 25'sd332050;
      5'd4:    a = 25'sd166669;
      5'd5:    a = 25'sd83416;
      5'd6:    a = 25'sd41718;
      5'd7:    a = 25'sd20860;
      5'd8:    a = 25'sd10430;
      5'd9:    a = 25'sd5215;
      5'd10:   a = 25'sd2608;
      5'd11:   a = 25'sd1304;
      5'd12:   a = 25'sd652;
      5'd13:   a = 25'sd326;
      5'd14:   a = 25'sd163;
      5'd15:   a = 25'sd81;
      5'd16:   a = 25'sd41;
      5'd17:   a = 25'sd20;
      5'd18:   a = 25'sd10;
      5'd19:   a = 25'sd5;
      5'd20:   a = 25'sd3;
      5'd21:   a = 25'sd1;
      5'd22:   a = 25'sd1;
      default: a = 25'sd0;
    endcase
    return a;
  endfunction

endpackage

### rtl/fm_discriminator_deemphasis_unit.sv
// FM polar discriminator: conjugate product, CORDIC atan2, gain, de-emphasis IIR.
// One sample is processed at a time: in_stall_o is high whenever the sequencer is not idle;
//   the CORDIC runs NITER = min(CORDIC_ITERATIONS, 24) rotations; a zero conjugate product skips the CORDIC loop.
// Rate is set by the shared multiplier (seven products), the one-rotation-per-cycle CORDIC and out_stall_i.
// Reset (async, active low): previous sample (1,0), filter state zero, registers to defaults.
`include "assert_macros.svh"

module fm_discriminator_deemphasis_unit
  import fdd_pkg::*;
#(
  parameter int unsigned SAMPLE_WIDTH      = 16,
  parameter int unsigned CORDIC_ITERATIONS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_i_i,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_q_i,
  input  logic                           restart_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic signed [AUDIO_W-1:0]      audio_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]           cfg_index_i,
  input  logic [CFG_DATA_W-1:0]          cfg_data_i
);

  localparam int unsigned NITER = (CORDIC_ITERATIONS < ANGLE_STEPS) ?
                                  CORDIC_ITERATIONS : ANGLE_STEPS;
  localparam int unsigned KW   = $clog2(NITER);
  localparam int unsigned MA   = ACC_W;
  localparam int unsigned MB   = (SAMPLE_WIDTH > 18) ? SAMPLE_WIDTH : 18;
  localparam int unsigned PW   = MA + MB;
  localparam int unsigned SW   = PW + 1;
  localparam int unsigned RW   = 2 * SAMPLE_WIDTH + 1;
  localparam int unsigned CW   = 2 * SAMPLE_WIDTH + 3;
  localparam int unsigned AR_W = ACC_W + 1;

  localparam logic [KW-1:0] K_LAST = KW'(NITER - 1);
  localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_ONE = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [PW-1:0]   DEMOD_RND = PW'(2048);
  localparam logic signed [SW-1:0]   ACC_RND   = SW'(32768);
  localparam logic signed [SW-1:0]   ACC_HI    = SW'(2147483647);
  localparam logic signed [SW-1:0]   ACC_LO    = ~ACC_HI;
  localparam logic signed [AR_W-1:0] AUD_RND   = AR_W'(128);
  localparam logic signed [AR_W-1:0] AUD_HI    = AR_W'(131071);
  localparam logic signed [AR_W-1:0] AUD_LO    = ~AUD_HI;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RE0, ST_RE1, ST_IM0, ST_IM1, ST_IMSUM, ST_PRE, ST_ITER,
    ST_GAIN, ST_ROUND, ST_FWD, ST_FBK, ST_ACC, ST_OUT
  } state_e;

  state_e state_q;
  logic [KW-1:0] k_q;
  logic out_valid_q;
  logic signed [AUDIO_W-1:0] audio_q;
  logic signed [SAMPLE_WIDTH-1:0] prev_i_q, prev_q_q, cur_i_q, cur_q_q;
  logic signed [ACC_W-1:0] acc_q;
  logic [CFG_DATA_W-1:0] gain_q, pole_q;

  logic signed [PW-1:0] prod_q;
  logic signed [RW-1:0] re_q, im_q;
  logic signed [CW-1:0] x_q, y_q;
  logic signed [PHASE_W-1:0] z_q;
  logic signed [DEMOD_W-1:0] demod_q;
  logic signed [SW-1:0] sum_q;

  logic in_acc, out_acc;
  logic signed [MA-1:0] mul_a;
  logic signed [MB-1:0] mul_b;
  logic signed [PW-1:0] mul_p;
  logic [16:0] fwd_wgt;
  logic signed [CW-1:0] re_x, im_x, dx, dy;
  logic signed [PHASE_W-1:0] step;
  logic prod_zero;
  logic signed [SW-1:0] acc_sum, acc_sh;
  logic signed [ACC_W-1:0] acc_d;
  logic signed [AR_W-1:0] aud_sum, aud_sh;
  logic signed [AUDIO_W-1:0] audio_d;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_acc     = out_valid_q && !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign audio_o     = audio_q;
  assign cfg_ready_o = 1'b1;

  // shared multiplier operand select
  assign fwd_wgt = 17'h10000 - 17'(pole_q);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_RE0: begin mul_a = MA'(cur_i_q); mul_b = MB'(prev_i_q); end
      ST_RE1: begin mul_a = MA'(cur_q_q); mul_b = MB'(prev_q_q); end
      ST_IM0: begin mul_a = MA'(cur_q_q); mul_b = MB'(prev_i_q); end
      ST_IM1: begin mul_a = MA'(cur_i_q); mul_b = MB'(prev_q_q); end
      ST_GAIN: begin mul_a = MA'(z_q); mul_b = MB'(gain_q); end
      ST_FWD: begin mul_a = MA'(demod_q); mul_b = MB'(fwd_wgt); end
      ST_FBK: begin mul_a = acc_q; mul_b = MB'(pole_q); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // CORDIC micro-rotation terms
  assign re_x      = CW'(re_q);
  assign im_x      = CW'(im_q);
  assign prod_zero = (re_q == '0) && (im_q == '0);
  assign dx        = y_q >>> k_q;
  assign dy        = x_q >>> k_q;
  assign step      = angle_step(5'(k_q));

  // filter update and output rounding
  always_comb begin
    acc_sum = sum_q + SW'(prod_q) + ACC_RND;
    acc_sh  = acc_sum >>> 16;
    if (acc_sh > ACC_HI) begin
      acc_d = ACC_W'(ACC_HI);
    end else if (acc_sh < ACC_LO) begin
      acc_d = ACC_W'(ACC_LO);
    end else begin
      acc_d = ACC_W'(acc_sh);
    end
    aud_sum = AR_W'(acc_q) + AUD_RND;
    aud_sh  = aud_sum >>> 8;
    if (aud_sh > AUD_HI) begin
      audio_d = AUDIO_W'(AUD_HI);
    end else if (aud_sh < AUD_LO) begin
      audio_d = AUDIO_W'(AUD_LO);
    end else begin
      audio_d = AUDIO_W'(aud_sh);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= GAIN_RESET;
      pole_q <= POLE_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == REG_GAIN) begin
        gain_q <= cfg_data_i;
      end else if (cfg_index_i == REG_POLE) begin
        pole_q <= cfg_data_i;
      end
    end
  end

  // sequencer, filter state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      k_q         <= '0;
      out_valid_q <= 1'b0;
      audio_q     <= '0;
      prev_i_q    <= SAMPLE_ONE;
      prev_q_q    <= '0;
      acc_q       <= '0;
    end else begin
      // in the output step a taken transaction is replaced by the new one
      if (out_acc && state_q != ST_OUT) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            state_q <= ST_RE0;
            if (restart_i) begin
              prev_i_q <= SAMPLE_ONE;
              prev_q_q <= '0;
              acc_q    <= '0;
            end
          end
        end
        ST_RE0:   state_q <= ST_RE1;
        ST_RE1:   state_q <= ST_IM0;
        ST_IM0:   state_q <= ST_IM1;
        ST_IM1:   state_q <= ST_IMSUM;
        ST_IMSUM: begin
          prev_i_q <= cur_i_q;
          prev_q_q <= cur_q_q;
          state_q  <= ST_PRE;
        end
        ST_PRE: begin
          k_q     <= '0;
          state_q <= prod_zero ? ST_GAIN : ST_ITER;
        end
        ST_ITER: begin
          if (k_q == K_LAST) begin
            state_q <= ST_GAIN;
          end else begin
            k_q <= k_q + 1'b1;
          end
        end
        ST_GAIN:  state_q <= ST_ROUND;
        ST_ROUND: state_q <= ST_FWD;
        ST_FWD:   state_q <= ST_FBK;
        ST_FBK:   state_q <= ST_ACC;
        ST_ACC: begin
          acc_q   <= acc_d;
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_valid_q || !out_stall_i) begin
            audio_q     <= audio_d;
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    prod_q <= mul_p;
    if (in_acc) begin
      cur_i_q <= sample_i_i;
      cur_q_q <= sample_q_i;
    end
    unique case (state_q)
      ST_RE1:   re_q <= RW'(prod_q);
      ST_IM0:   re_q <= re_q + RW'(prod_q);
      ST_IM1:   im_q <= RW'(prod_q);
      ST_IMSUM: im_q <= im_q - RW'(prod_q);
      ST_PRE: begin
        if (prod_zero) begin
          z_q <= '0;
        end else if (re_q < 0) begin
          // left half plane: rotate by pi first
          x_q <= -re_x;
          y_q <= -im_x;
          z_q <= (im_q < 0) ? -ANGLE_PI : ANGLE_PI;
        end else begin
          x_q <= re_x;
          y_q <= im_x;
          z_q <= '0;
        end
      end
      ST_ITER: begin
        if (!y_q[CW-1]) begin
          x_q <= x_q + dx;
          y_q <= y_q - dy;
          z_q <= z_q + step;
        end else begin
          x_q <= x_q - dx;
          y_q <= y_q + dy;
          z_q <= z_q - step;
        end
      end
      ST_ROUND: demod_q <= DEMOD_W'((prod_q + DEMOD_RND) >>> 12);
      ST_FBK:   sum_q   <= SW'(prod_q);
      default: begin
      end
    endcase
  end

  `ASSERT_NEVER(a_k_range, state_q == ST_ITER && k_q > K_LAST,
                "CORDIC step counter past last rotation")
  `ASSERT_CLK(a_restart_clears, in_acc && restart_i |=> acc_q == '0 && prev_q_q == '0,
              "restart did not clear filter and previous sample")
  `ASSERT_CLK(a_out_from_seq, $rose(out_valid_q) |-> $past(state_q) == ST_OUT,
              "output transaction raised outside the output step")
  `ASSERT_CLK(a_out_no_overwrite, state_q == ST_OUT && out_valid_q && out_stall_i
              |=> state_q == ST_OUT && $stable(audio_q),
              "pending audio overwritten")

endmodule
